### design/swrad_pkg.sv
// Shared types for the stack with remove-at-depth block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package swrad_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the operands of an accepted transfer
    logic exec;  // apply the operation and register the result
  } dp_cmd_t;

endpackage

`default_nettype wire

### design/swrad_ctrl.sv
// Controller state machine: accept, execute, present the result.
// Depends on swrad_pkg for the state enum and command struct.
`default_nettype none

module swrad_ctrl
  import swrad_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  output logic      done_o,
  output dp_cmd_t   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    busy       = 1'b1;
    done_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/swrad_datapath.sv
// Datapath: operand registers, a row of shifting cells (cell 0 is the top),
// the entry count and the result registers. Depends on swrad_pkg.
`default_nettype none

module swrad_datapath
  import swrad_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  input  wire logic        [1:0]  operation_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic        [4:0]  position_i,
  output logic signed      [31:0] removed_value_o,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] top_value_o,
  output logic             [4:0]  entry_count_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;
  // Positions are five bits wide, so only the upper cells can be removed.
  localparam int NR = (DEPTH < 31) ? DEPTH : 31;

  logic        [1:0]  op_q;
  logic signed [31:0] value_q;
  logic        [4:0]  pos_q;

  logic signed [31:0] cells_q [DEPTH];
  logic signed [31:0] cells_d [DEPTH];
  logic [CW-1:0]      count_q, count_d;

  logic signed [31:0] removed_q, removed_d;
  logic [1:0]         status_q, status_d;

  logic signed [31:0] pick;
  logic [PW-1:0]      pos_ext, count_ext;
  logic [31:0]        count_wide;

  assign pos_ext   = PW'(pos_q);
  assign count_ext = PW'(count_q);

  // Select the word at the requested position.
  always_comb begin
    pick = '0;
    for (int i = 0; i < NR; i++) begin
      if (32'(pos_q) == i + 1) begin
        pick = cells_q[i];
      end
    end
  end

  always_comb begin
    cells_d   = cells_q;
    count_d   = count_q;
    removed_d = '0;
    status_d  = ST_OK;
    case (op_q)
      OP_PUSH: begin
        if (count_q == CW'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          cells_d[0] = value_q;
          for (int i = 1; i < DEPTH; i++) begin
            cells_d[i] = cells_q[i-1];
          end
          count_d = count_q + CW'(1);
        end
      end
      OP_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          removed_d = cells_q[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            cells_d[i] = cells_q[i+1];
          end
          count_d = count_q - CW'(1);
        end
      end
      OP_REMOVE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_q == '0 || pos_ext > count_ext) begin
          status_d = ST_RANGE;
        end else begin
          removed_d = pick;
          // Close the gap: every cell below the position moves up one place.
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (32'(pos_q) <= i + 1) begin
              cells_d[i] = cells_q[i+1];
            end
          end
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    if (cmd_i.exec) begin
      cells_q   <= cells_d;
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign count_wide      = 32'(count_q);
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign top_value_o     = (count_q == '0) ? 32'sd0 : cells_q[0];
  assign entry_count_o   = count_wide[4:0];

endmodule

`default_nettype wire

### design/stack_with_remove_at_depth.sv
// Bounded LIFO stack of signed words with removal at a depth from the top.
// done_o rises when the controller reaches its result state, after the
// accept and execute states. A new request is taken only once the result
// is shown (accept, execute, result), set by the controller sequence.
// Results show for one cycle only; the receiver cannot stall.
// Reset (rst_ni, async, active low) empties the stack and returns to idle.
`default_nettype none

module stack_with_remove_at_depth
  import swrad_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  operation_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic        [4:0]  position_i,
  output logic                    done_o,
  output logic signed      [31:0] removed_value_o,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] top_value_o,
  output logic             [4:0]  entry_count_o
);

  dp_cmd_t cmd;

  swrad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  swrad_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .top_value_o     (top_value_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

`default_nettype wire

### test/stack_with_remove_at_depth_tb.sv
// Self-checking testbench for stack_with_remove_at_depth: directed corner cases, then
// random push/pop/remove and unused-op traffic under several start-gap profiles. Depends on swrad_pkg.
`timescale 1ns / 100ps

module stack_with_remove_at_depth_tb;
  import swrad_pkg::*;

  localparam int DEPTH = 16;
  localparam int CLK_HALF = 6;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_PHASE = 270;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] removed;
    status_e            status;
    logic signed [31:0] top;
    logic        [4:0]  count;
  } stack_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic        [1:0]  operation_i = OP_PUSH;
  logic signed [31:0] value_i = '0;
  logic        [4:0]  position_i = '0;
  logic               busy;
  logic               done_o;
  logic signed [31:0] removed_value_o;
  logic        [1:0]  status_o;
  logic signed [31:0] top_value_o;
  logic        [4:0]  entry_count_o;

  stack_with_remove_at_depth #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .done_o         (done_o),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .top_value_o    (top_value_o),
    .entry_count_o  (entry_count_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Shadow copy of the stack; entry 0 is the bottom.
  logic [31:0]   shadow_words [DEPTH];
  int unsigned   shadow_fill = 0;
  stack_result_t pending_results [$];
  int            mismatch_count = 0;
  int            sender_idle_pct = 0;
  int            idle_cycles = 0;

  function automatic stack_result_t apply_stack_op(input logic [1:0] op,
                                                   input logic [31:0] word,
                                                   input logic [4:0] pos);
    stack_result_t r;
    int unsigned   idx;
    r.removed = '0;
    r.status  = ST_OK;
    if (op == OP_PUSH) begin
      if (shadow_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_words[shadow_fill] = word;
        shadow_fill++;
      end
    end else if (op == OP_POP) begin
      if (shadow_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        shadow_fill--;
        r.removed = shadow_words[shadow_fill];
      end
    end else if (op == OP_REMOVE) begin
      if (shadow_fill == 0) begin
        r.status = ST_EMPTY;
      end else if (pos == 0 || pos > shadow_fill) begin
        r.status = ST_RANGE;
      end else begin
        idx = shadow_fill - pos;
        r.removed = shadow_words[idx];
        // close the gap, keep order of the rest
        for (int unsigned i = idx; i + 1 < shadow_fill; i++) begin
          shadow_words[i] = shadow_words[i + 1];
        end
        shadow_fill--;
      end
    end
    r.top   = (shadow_fill == 0) ? '0 : shadow_words[shadow_fill - 1];
    r.count = shadow_fill[4:0];
    return r;
  endfunction

  // Hold start high across back-to-back transfers; drop it only for a gap.
  task automatic send_op(input logic [1:0] op, input logic [31:0] word,
                         input logic [4:0] pos);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start       <= 1'b1;
    operation_i <= op;
    value_i     <= word;
    position_i  <= pos;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(apply_stack_op(op, word, pos));
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Alternate fill-biased and drain-biased runs so both full and empty get hit.
  task automatic run_random(input int n_items);
    logic [1:0] op;
    logic [4:0] pos;
    int         sel;
    bit         filling;
    filling = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) filling = ~filling;
      sel = $urandom_range(99);
      if (sel < 5) op = OP_UNUSED;
      else if (filling) op = (sel < 70) ? OP_PUSH : (sel < 82) ? OP_POP : OP_REMOVE;
      else op = (sel < 20) ? OP_PUSH : (sel < 55) ? OP_POP : OP_REMOVE;
      if (shadow_fill > 0 && $urandom_range(99) < 80) begin
        pos = 5'($urandom_range(shadow_fill, 1));
      end else begin
        pos = 5'($urandom_range(31));
      end
      send_op(op, random_word(), pos);
    end
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    send_op(OP_POP,    32'h1234_5678, 5'd0);
    send_op(OP_REMOVE, 32'h0,         5'd0);
    send_op(OP_REMOVE, 32'h0,         5'd31);
    send_op(OP_UNUSED, 32'hdead_beef, 5'd3);
    send_op(OP_PUSH,   32'h8000_0000, 5'd0);
    send_op(OP_PUSH,   32'h7fff_ffff, 5'd31);
    send_op(OP_PUSH,   32'h0000_0000, 5'd0);
    send_op(OP_PUSH,   32'hffff_ffff, 5'd0);
    send_op(OP_REMOVE, 32'h0,         5'd0);
    send_op(OP_REMOVE, 32'h0,         5'd5);
    send_op(OP_REMOVE, 32'h0,         5'd31);
    send_op(OP_UNUSED, 32'h5555_aaaa, 5'd1);
    send_op(OP_REMOVE, 32'h0,         5'd4);
    send_op(OP_REMOVE, 32'h0,         5'd2);
    send_op(OP_REMOVE, 32'h0,         5'd1);
    send_op(OP_POP,    32'h0,         5'd0);
    send_op(OP_POP,    32'h0,         5'd0);
  endtask

  task automatic test_back_to_back();
    sender_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
  endtask

  task automatic test_sparse_starts();
    sender_idle_pct = 88;
    run_random(ITEMS_PER_PHASE);
  endtask

  task automatic test_mixed_gaps();
    sender_idle_pct = 26;
    run_random(ITEMS_PER_PHASE);
  endtask

  always @(posedge clk_i) begin
    stack_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("ERROR: result with nothing expected: removed=%h status=%0d top=%h count=%0d",
                   removed_value_o, status_o, top_value_o, entry_count_o);
        end
      end else begin
        exp_r = pending_results.pop_front();
        if (removed_value_o !== exp_r.removed || status_o !== exp_r.status ||
            top_value_o !== exp_r.top || entry_count_o !== exp_r.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR: expected removed=%h status=%0d top=%h count=%0d",
                     exp_r.removed, exp_r.status, exp_r.top, exp_r.count);
            $display("       actual   removed=%h status=%0d top=%h count=%0d",
                     removed_value_o, status_o, top_value_o, entry_count_o);
          end
        end
      end
    end
  end

  // Stall watchdog: count cycles without an input or result transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_back_to_back();
    test_sparse_starts();
    test_mixed_gaps();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
